FILE: sv/lfpe_pkg.sv
package lfpe_pkg;

    localparam int MAX_FACTORS = 16;
    localparam int N_CELLS     = MAX_FACTORS + 1;
    localparam int CNT_W       = $clog2(MAX_FACTORS + 1);
    localparam int COEF_W      = 64;
    localparam int HALF_W      = COEF_W / 2;
    localparam int FAC_W       = 16;
    localparam int DEG_W       = 5;

    // multiply phases of one factor: own value times b, then old neighbor times a
    localparam logic [1:0] PH_SELF_LO = 2'd0;
    localparam logic [1:0] PH_SELF_HI = 2'd1;
    localparam logic [1:0] PH_NB_LO   = 2'd2;
    localparam logic [1:0] PH_NB_HI   = 2'd3;

    typedef struct packed {
        logic       mul_en;
        logic [1:0] phase;
        logic       clear;
    } t_cell_ctrl;

endpackage

FILE: sv/lfpe_in_if.sv
interface lfpe_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [lfpe_pkg::FAC_W-1:0]      x_coeff;
    logic signed [lfpe_pkg::FAC_W-1:0]      const_term;
    logic                                   last_factor;

    modport source (output valid, output x_coeff, output const_term, output last_factor,
                    input ready);
    modport sink (input valid, input x_coeff, input const_term, input last_factor,
                  output ready);
endinterface

FILE: sv/lfpe_out_if.sv
interface lfpe_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [lfpe_pkg::COEF_W-1:0]     coeff_value;
    logic [lfpe_pkg::DEG_W-1:0]             degree;
    logic                                   last_coeff;

    modport source (output valid, output coeff_value, output degree, output last_coeff,
                    input ready);
    modport sink (input valid, input coeff_value, input degree, input last_coeff,
                  output ready);
endinterface

FILE: sv/lfpe_cell.sv
module lfpe_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lfpe_pkg::t_cell_ctrl                i_ctrl,
    input  logic signed [lfpe_pkg::FAC_W-1:0]   i_a,
    input  logic signed [lfpe_pkg::FAC_W-1:0]   i_b,
    input  logic                                i_base,
    input  logic [lfpe_pkg::COEF_W-1:0]         i_prev,
    output logic [lfpe_pkg::COEF_W-1:0]         o_coef
);
    localparam int PROD_W = lfpe_pkg::HALF_W + 1 + lfpe_pkg::FAC_W;

    logic [lfpe_pkg::COEF_W-1:0]          r_coef;
    logic [lfpe_pkg::COEF_W-1:0]          r_acc;
    logic signed [lfpe_pkg::HALF_W:0]     w_mop;
    logic signed [lfpe_pkg::FAC_W-1:0]    w_fop;
    logic                                 w_hi;
    logic signed [PROD_W-1:0]             w_prod;
    logic [lfpe_pkg::COEF_W-1:0]          w_term;
    logic [lfpe_pkg::COEF_W-1:0]          w_sum;
    logic [lfpe_pkg::COEF_W-1:0]          w_base;

    assign w_base = lfpe_pkg::COEF_W'(i_base);

    always_comb begin
        unique case (i_ctrl.phase)
            lfpe_pkg::PH_SELF_LO: begin
                w_mop = {1'b0, r_coef[lfpe_pkg::HALF_W-1:0]};
                w_fop = i_b;
                w_hi  = 1'b0;
            end
            lfpe_pkg::PH_SELF_HI: begin
                w_mop = {1'b0, r_coef[lfpe_pkg::COEF_W-1:lfpe_pkg::HALF_W]};
                w_fop = i_b;
                w_hi  = 1'b1;
            end
            lfpe_pkg::PH_NB_LO: begin
                w_mop = {1'b0, i_prev[lfpe_pkg::HALF_W-1:0]};
                w_fop = i_a;
                w_hi  = 1'b0;
            end
            default: begin
                w_mop = {1'b0, i_prev[lfpe_pkg::COEF_W-1:lfpe_pkg::HALF_W]};
                w_fop = i_a;
                w_hi  = 1'b1;
            end
        endcase
    end

    // 33x16 signed product; high halves only matter mod 2^32
    assign w_prod = PROD_W'(w_mop) * PROD_W'(w_fop);
    assign w_term = w_hi ? {w_prod[lfpe_pkg::HALF_W-1:0], {lfpe_pkg::HALF_W{1'b0}}}
                         : lfpe_pkg::COEF_W'(w_prod);
    assign w_sum  = ((i_ctrl.phase == lfpe_pkg::PH_SELF_LO) ? '0 : r_acc) + w_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= w_base;
        end else if (i_ctrl.clear) begin
            r_coef <= w_base;
        end else if (i_ctrl.mul_en && i_ctrl.phase == lfpe_pkg::PH_NB_HI) begin
            r_coef <= w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_acc <= w_sum;
        end
    end

    assign o_coef = r_coef;
endmodule

FILE: sv/linear_factor_polynomial_expand.sv
// Linear factor product expander.
// Input channel i_in carries one factor (x_coeff*x + const_term) per item;
// last_factor marks the final factor of a product. Output channel o_out
// carries the coefficients of the expanded product, highest degree first,
// down to the constant term, which has last_coeff set.
// A row of MAX_FACTORS+1 coefficient cells holds the running product. Each
// cell owns one 33x16 multiplier and works through each factor in order
// (low and high half of its own value times b, then of its lower neighbor's
// old value times a); all cells commit together. i_in.ready is high only in
// idle, so a new factor is not taken until the multiply of the last is done.
// After a last factor, the first coefficient is loaded into the output
// register once the multiply is done; the rest follow one per cycle while
// o_out.ready stays high. A stall on o_out holds the current coefficient in
// the output register and pauses the row. Once the constant term is loaded,
// the cells reset to the polynomial 1 and the next factor can be taken while
// it is still waiting. Factors beyond MAX_FACTORS are dropped, though their
// last mark still starts output.
// Synchronous reset sets the product to 1 and empties output.
module linear_factor_polynomial_expand (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lfpe_in_if.sink     i_in,
    lfpe_out_if.source  o_out
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                               r_state;
    logic [1:0]                               r_phase;
    logic [lfpe_pkg::CNT_W-1:0]               r_count;
    logic [lfpe_pkg::CNT_W-1:0]               r_deg;
    logic                                     r_last;
    logic signed [lfpe_pkg::FAC_W-1:0]        r_a;
    logic signed [lfpe_pkg::FAC_W-1:0]        r_b;
    logic                                     r_ovalid;
    logic [lfpe_pkg::COEF_W-1:0]              r_ocoef;
    logic [lfpe_pkg::DEG_W-1:0]               r_odeg;
    logic                                     r_olast;

    logic [lfpe_pkg::COEF_W-1:0]              w_coef [lfpe_pkg::N_CELLS];
    lfpe_pkg::t_cell_ctrl                     w_ctrl;
    logic                                     w_accept;
    logic                                     w_room;
    logic                                     w_load;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_room     = (r_count < lfpe_pkg::CNT_W'(lfpe_pkg::MAX_FACTORS));
    assign w_load     = (r_state == ST_EMIT) && (!r_ovalid || o_out.ready);

    assign w_ctrl.mul_en = (r_state == ST_MUL);
    assign w_ctrl.phase  = r_phase;
    assign w_ctrl.clear  = w_load && (r_deg == '0);

    for (genvar k = 0; k < lfpe_pkg::N_CELLS; k++) begin : g_cell
        logic [lfpe_pkg::COEF_W-1:0] w_prev;
        if (k == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_next
            assign w_prev = w_coef[k-1];
        end
        lfpe_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_a     (r_a),
            .i_b     (r_b),
            .i_base  (k == 0),
            .i_prev  (w_prev),
            .o_coef  (w_coef[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= lfpe_pkg::PH_SELF_LO;
            r_count <= '0;
            r_deg   <= '0;
            r_last  <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_last <= i_in.last_factor;
                        r_deg  <= r_count;
                        if (w_room) begin
                            r_state <= ST_MUL;
                            r_phase <= lfpe_pkg::PH_SELF_LO;
                        end else if (i_in.last_factor) begin
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_MUL: begin
                    r_phase <= r_phase + 2'd1;
                    if (r_phase == lfpe_pkg::PH_NB_HI) begin
                        r_count <= r_count + 1'b1;
                        r_deg   <= r_count + 1'b1;
                        r_state <= r_last ? ST_EMIT : ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (w_load) begin
                        if (r_deg == '0) begin
                            r_count <= '0;
                            r_state <= ST_IDLE;
                        end else begin
                            r_deg <= r_deg - 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a <= i_in.x_coeff;
            r_b <= i_in.const_term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ocoef <= w_coef[r_deg];
            r_odeg  <= lfpe_pkg::DEG_W'(r_deg);
            r_olast <= (r_deg == '0);
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.coeff_value = r_ocoef;
    assign o_out.degree      = r_odeg;
    assign o_out.last_coeff  = r_olast;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= lfpe_pkg::CNT_W'(lfpe_pkg::MAX_FACTORS))
        else $error("factor count beyond capacity");

    a_emit_deg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_deg <= r_count))
        else $error("emit degree beyond factor count");

    a_clear_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.clear |=> (r_count == '0) && (w_coef[0] == lfpe_pkg::COEF_W'(1))
                         && (r_state == ST_IDLE))
        else $error("row not back to unit product after run");

    a_last_deg0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_olast) |-> (r_odeg == '0))
        else $error("run ends on a nonzero degree");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EMIT) && r_ovalid && !o_out.ready)
            |=> (r_state == $past(r_state)) && (r_deg == $past(r_deg)))
        else $error("row advanced under output stall");
endmodule

FILE: tb/tb_top.sv
module tb_top;
    import lfpe_pkg::*;

    typedef struct packed {
        logic [FAC_W-1:0] x;
        logic [FAC_W-1:0] b;
        logic             last;
        logic             drain;
    } factor_t;

    typedef struct packed {
        logic [COEF_W-1:0] value;
        logic [DEG_W-1:0]  deg;
        logic              last;
    } coef_t;

    logic i_clk;
    logic i_rst_n;

    lfpe_in_if  in_ch();
    lfpe_out_if out_ch();

    linear_factor_polynomial_expand i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    factor_t           factor_q[$];
    coef_t             coeff_expect[$];
    logic [COEF_W-1:0] prod_coef[N_CELLS];
    int                n_factors;
    int                n_in_acc  = 0;
    int                n_err     = 0;
    int                hold_left = 0;
    logic              hold_done = 1'b0;
    coef_t             exp_c;

    wire calm = (n_in_acc >= 100) && (n_in_acc < 160);

    always #10 i_clk = ~i_clk;

    task automatic reset_product();
        foreach (prod_coef[k]) prod_coef[k] = '0;
        prod_coef[0] = 1;
        n_factors = 0;
    endtask

    // multiply the running product by (x*X + b); on a last item queue its coefficients
    task automatic expand_factor(factor_t f);
        logic [COEF_W-1:0] a;
        logic [COEF_W-1:0] b;
        coef_t             r;
        a = {{(COEF_W-FAC_W){f.x[FAC_W-1]}}, f.x};
        b = {{(COEF_W-FAC_W){f.b[FAC_W-1]}}, f.b};
        if (n_factors < MAX_FACTORS) begin
            for (int k = n_factors + 1; k > 0; k--)
                prod_coef[k] = b * prod_coef[k] + a * prod_coef[k-1];
            prod_coef[0] = b * prod_coef[0];
            n_factors++;
        end
        if (f.last) begin
            for (int d = n_factors; d >= 0; d--) begin
                r.value = prod_coef[d];
                r.deg   = DEG_W'(d);
                r.last  = (d == 0);
                coeff_expect.push_back(r);
            end
            reset_product();
        end
    endtask

    task automatic add_factor(logic [FAC_W-1:0] x, logic [FAC_W-1:0] b, logic last,
                              logic drain);
        factor_t f;
        f.x     = x;
        f.b     = b;
        f.last  = last;
        f.drain = drain;
        factor_q.push_back(f);
    endtask

    function automatic logic [FAC_W-1:0] pick_coef();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            4: return 16'h0001;
            default: return FAC_W'($urandom);
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_ch.ready) begin
            in_ch.valid <= 1'b1;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expand_factor(factor_q.pop_front());
                n_in_acc++;
            end
            if (factor_q.size() != 0 && (calm || $urandom_range(0, 99) >= 25) &&
                (!factor_q[0].drain || coeff_expect.size() == 0)) begin
                in_ch.valid       <= 1'b1;
                in_ch.x_coeff     <= factor_q[0].x;
                in_ch.const_term  <= factor_q[0].b;
                in_ch.last_factor <= factor_q[0].last;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // long receiver stall, once, while results are pending
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && n_in_acc >= 60 && coeff_expect.size() != 0) begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (coeff_expect.size() == 0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("unexpected coefficient %h degree %0d last %b",
                                 out_ch.coeff_value, out_ch.degree, out_ch.last_coeff);
                end else begin
                    exp_c = coeff_expect.pop_front();
                    if (out_ch.coeff_value !== exp_c.value || out_ch.degree !== exp_c.deg ||
                        out_ch.last_coeff !== exp_c.last) begin
                        n_err++;
                        if (n_err <= 10)
                            $display("mismatch: exp %h deg %0d last %b, got %h deg %0d last %b",
                                     exp_c.value, exp_c.deg, exp_c.last, out_ch.coeff_value,
                                     out_ch.degree, out_ch.last_coeff);
                    end
                end
            end
            out_ch.ready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 25);
        end
    end

    initial begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int len;
        int kind;
        logic drain;
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.x_coeff      = '0;
        in_ch.const_term   = '0;
        in_ch.last_factor  = 1'b0;
        out_ch.ready       = 1'b0;
        reset_product();

        // directed: extremes, single-factor products, zero product
        add_factor(16'h0001, 16'h0000, 1'b1, 1'b0);
        add_factor(16'h8000, 16'h8000, 1'b0, 1'b0);
        add_factor(16'h7fff, 16'h7fff, 1'b0, 1'b0);
        add_factor(16'hffff, 16'h8000, 1'b1, 1'b0);
        add_factor(16'h0000, 16'h0000, 1'b1, 1'b0);
        add_factor(16'h8000, 16'h7fff, 1'b1, 1'b0);
        // full product that wraps, then dropped factors with the last mark on a dropped one
        for (int i = 0; i < MAX_FACTORS; i++)
            add_factor(i[0] ? 16'h7fff : 16'h8000, i[0] ? 16'h8000 : 16'h7fff, 1'b0, 1'b0);
        add_factor(16'h0005, 16'h0007, 1'b0, 1'b0);
        add_factor(16'hfffd, 16'h0009, 1'b1, 1'b0);

        drain = 1'b1;
        while (factor_q.size() < 230) begin
            if (factor_q.size() >= 150 && factor_q.size() < 170)
                drain = 1'b1;
            kind = $urandom_range(0, 9);
            if (kind == 9) begin
                add_factor(pick_coef(), pick_coef(), 1'($urandom), drain);
            end else begin
                len = (kind == 8) ? $urandom_range(MAX_FACTORS + 1, MAX_FACTORS + 4)
                    : (kind == 7) ? MAX_FACTORS : $urandom_range(1, 8);
                for (int i = 1; i <= len; i++)
                    add_factor(pick_coef(), pick_coef(), i == len, drain && i == 1);
            end
            drain = 1'b0;
        end
        add_factor(pick_coef(), pick_coef(), 1'b1, 1'b0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (factor_q.size() != 0 || in_ch.valid) @(posedge i_clk);
        while (coeff_expect.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (n_err == 0 && coeff_expect.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
